[sv/sphav_pkg.sv]
// shared types, register indexes and fixed widths for the sph artificial viscosity unit
// no dependencies
`default_nettype none

package sphav_pkg;

    localparam int CFG_W      = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_W     = 64;
    localparam int SUM_W      = 66;
    localparam int DOT_W      = SUM_W - FRAC_BITS;
    localparam int M_W        = 48;
    localparam int DEN_W      = 41;
    localparam int Q_W        = 62;
    localparam int RHO_W      = 31;
    localparam int HH_W       = 2 * CFG_W;
    localparam int ETA_W      = 26;
    localparam int QUOT_STEPS = Q_W;
    localparam int NORM_STEPS = 31;
    localparam int FRONT_LAT  = 3;
    localparam int SCALE_MULS = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_COEFF      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOUND_SPEED      = 2'd2;

    localparam logic [CFG_W-1:0] SMOOTHING_LENGTH_RST = 31'd65536;
    localparam logic [CFG_W-1:0] ALPHA_COEFF_RST      = 31'd6554;
    localparam logic [CFG_W-1:0] SOUND_SPEED_RST      = 31'd4105293;

    // 0.01 in q0.32
    localparam logic [ETA_W-1:0] ETA_FRAC = 26'd42949673;

    localparam logic signed [31:0] VISC_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic signed [31:0] rel_pos_x;
        logic signed [31:0] rel_pos_y;
        logic signed [31:0] rel_pos_z;
        logic signed [31:0] rel_vel_x;
        logic signed [31:0] rel_vel_y;
        logic signed [31:0] rel_vel_z;
        logic [30:0]        dist_squared;
        logic [30:0]        density_a;
        logic [30:0]        density_b;
    } in_t;

    typedef struct packed {
        logic signed [31:0] visc_term;
        logic               approaching;
        logic               saturated;
    } out_t;

    typedef struct packed {
        logic [CFG_W-1:0] smoothing_length;
        logic [CFG_W-1:0] alpha_coeff;
        logic [CFG_W-1:0] sound_speed;
    } cfg_t;

    typedef struct packed {
        logic [M_W-1:0]   m;
        logic [DEN_W-1:0] den;
        logic [RHO_W-1:0] robar;
        logic             neg;
        logic             zero_div;
    } front_t;

    typedef struct packed {
        logic [Q_W-1:0]   q;
        logic [RHO_W-1:0] robar;
        logic             neg;
        logic             zero_div;
        logic             ovf;
    } quot_t;

endpackage

`default_nettype wire

[sv/sphav_front.sv]
// front stages: dot product, eta squared term, divisor and mean density
// depends on sphav_pkg
`default_nettype none

module sphav_front import sphav_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   en,
    input  logic   in_valid,
    input  in_t    in_data,
    input  cfg_t   cfg,
    output logic   out_valid,
    output front_t out_data
);

    logic [FRONT_LAT-1:0] vld_reg;

    logic signed [PROD_W-1:0] prod_next [3];
    logic signed [PROD_W-1:0] prod_reg  [3];
    logic [HH_W-1:0]          hh_reg;
    logic [RHO_W-1:0]         rr2_a_reg;
    logic [RHO_W-1:0]         robar_a_reg;
    logic [RHO_W:0]           rho_sum;

    logic signed [SUM_W-1:0]  sum_next;
    logic signed [SUM_W-1:0]  sum_reg;
    logic [31+ETA_W:0]        eta_lo_full;
    logic [55:0]              eta_hi_reg;
    logic [ETA_W-1:0]         eta_lo_reg;
    logic [RHO_W-1:0]         rr2_b_reg;
    logic [RHO_W-1:0]         robar_b_reg;

    logic [DOT_W-1:0]         m_full;
    logic [56:0]              eta_sum;
    logic [DEN_W-1:0]         den_next;
    front_t                   front_reg;

    assign prod_next[0] = in_data.rel_pos_x * in_data.rel_vel_x;
    assign prod_next[1] = in_data.rel_pos_y * in_data.rel_vel_y;
    assign prod_next[2] = in_data.rel_pos_z * in_data.rel_vel_z;
    assign rho_sum      = {1'b0, in_data.density_a} + {1'b0, in_data.density_b};

    assign sum_next    = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[2]);
    assign eta_lo_full = hh_reg[31:0] * ETA_FRAC;

    assign m_full   = DOT_W'(0) - sum_reg[SUM_W-1:FRAC_BITS];
    assign eta_sum  = {1'b0, eta_hi_reg} + 57'(eta_lo_reg);
    assign den_next = DEN_W'(rr2_b_reg) + eta_sum[56:FRAC_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[FRONT_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // stage a
            prod_reg[0] <= prod_next[0];
            prod_reg[1] <= prod_next[1];
            prod_reg[2] <= prod_next[2];
            hh_reg      <= cfg.smoothing_length * cfg.smoothing_length;
            rr2_a_reg   <= in_data.dist_squared;
            robar_a_reg <= rho_sum[RHO_W:1];
            // stage b
            sum_reg     <= sum_next;
            eta_hi_reg  <= hh_reg[HH_W-1:32] * ETA_FRAC;
            eta_lo_reg  <= eta_lo_full[31+ETA_W:32];
            rr2_b_reg   <= rr2_a_reg;
            robar_b_reg <= robar_a_reg;
            // stage c
            front_reg.m        <= m_full[M_W-1:0];
            front_reg.den      <= den_next;
            front_reg.robar    <= robar_b_reg;
            front_reg.neg      <= sum_reg[SUM_W-1];
            front_reg.zero_div <= (den_next == '0) || (robar_b_reg == '0);
        end
    end

    assign out_valid = vld_reg[FRONT_LAT-1];
    assign out_data  = front_reg;

endmodule

`default_nettype wire

[sv/sphav_quot.sv]
// pipelined restoring divider, one quotient bit per stage: q = (m << 16) / den
// depends on sphav_pkg
`default_nettype none

module sphav_quot import sphav_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   en,
    input  logic   in_valid,
    input  front_t in_data,
    output logic   out_valid,
    output quot_t  out_data
);

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [Q_W-1:0]   qx;
        logic [DEN_W-1:0] den;
        logic [RHO_W-1:0] robar;
        logic             neg;
        logic             zero_div;
        logic             ovf;
    } qstage_t;

    logic [QUOT_STEPS:0] vld_reg;
    qstage_t             st_reg [0:QUOT_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[QUOT_STEPS-1:0], in_valid};
        end
    end

    // quotient of 2^62 or more shows as top dividend bits already >= divisor
    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0].rem      <= DEN_W'(in_data.m[M_W-1:Q_W-FRAC_BITS]);
            st_reg[0].ovf      <= DEN_W'(in_data.m[M_W-1:Q_W-FRAC_BITS]) >= in_data.den;
            st_reg[0].qx       <= {in_data.m[Q_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
            st_reg[0].den      <= in_data.den;
            st_reg[0].robar    <= in_data.robar;
            st_reg[0].neg      <= in_data.neg;
            st_reg[0].zero_div <= in_data.zero_div;
        end
    end

    for (genvar j = 0; j < QUOT_STEPS; j++) begin : g_step
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           take;

        assign trial = {st_reg[j].rem, st_reg[j].qx[Q_W-1]};
        assign diff  = trial - {1'b0, st_reg[j].den};
        assign take  = trial >= {1'b0, st_reg[j].den};

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[j+1].rem      <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                st_reg[j+1].qx       <= {st_reg[j].qx[Q_W-2:0], take};
                st_reg[j+1].den      <= st_reg[j].den;
                st_reg[j+1].robar    <= st_reg[j].robar;
                st_reg[j+1].neg      <= st_reg[j].neg;
                st_reg[j+1].zero_div <= st_reg[j].zero_div;
                st_reg[j+1].ovf      <= st_reg[j].ovf;
            end
        end
    end

    assign out_valid         = vld_reg[QUOT_STEPS];
    assign out_data.q        = st_reg[QUOT_STEPS].qx;
    assign out_data.robar    = st_reg[QUOT_STEPS].robar;
    assign out_data.neg      = st_reg[QUOT_STEPS].neg;
    assign out_data.zero_div = st_reg[QUOT_STEPS].zero_div;
    assign out_data.ovf      = st_reg[QUOT_STEPS].ovf;

endmodule

`default_nettype wire

[sv/sphav_scale.sv]
// three q16.16 scalings by h, alpha and cbar, two stages each
// depends on sphav_pkg
`default_nettype none

module sphav_scale import sphav_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  quot_t in_data,
    input  cfg_t  cfg,
    output logic  out_valid,
    output quot_t out_data
);

    localparam int HI_W  = Q_W - 32 + CFG_W;
    localparam int LO_W  = 32 + CFG_W;
    localparam int CAP_W = 46;

    typedef struct packed {
        logic [HI_W-1:0] hi;
        logic [LO_W-1:0] lo;
        quot_t           base;
    } part_t;

    logic [2*SCALE_MULS-1:0] vld_reg;
    logic [CFG_W-1:0]        coef [SCALE_MULS];
    quot_t                   stage_in [SCALE_MULS+1];
    part_t                   pr_reg [SCALE_MULS];
    quot_t                   sq_reg [SCALE_MULS];

    assign coef[0]     = cfg.smoothing_length;
    assign coef[1]     = cfg.alpha_coeff;
    assign coef[2]     = cfg.sound_speed;
    assign stage_in[0] = in_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[2*SCALE_MULS-2:0], in_valid};
        end
    end

    for (genvar i = 0; i < SCALE_MULS; i++) begin : g_mul
        logic [Q_W:0] r;

        assign r = {1'b0, pr_reg[i].hi[CAP_W-1:0], {FRAC_BITS{1'b0}}}
                 + (Q_W+1)'(pr_reg[i].lo[LO_W-1:FRAC_BITS]);

        always_ff @(posedge aclk) begin
            if (en) begin
                pr_reg[i].hi   <= stage_in[i].q[Q_W-1:32] * coef[i];
                pr_reg[i].lo   <= stage_in[i].q[31:0] * coef[i];
                pr_reg[i].base <= stage_in[i];

                sq_reg[i].q        <= r[Q_W-1:0];
                sq_reg[i].robar    <= pr_reg[i].base.robar;
                sq_reg[i].neg      <= pr_reg[i].base.neg;
                sq_reg[i].zero_div <= pr_reg[i].base.zero_div;
                sq_reg[i].ovf      <= pr_reg[i].base.ovf || r[Q_W]
                                    || (pr_reg[i].hi[HI_W-1:CAP_W] != '0);
            end
        end

        assign stage_in[i+1] = sq_reg[i];
    end

    assign out_valid = vld_reg[2*SCALE_MULS-1];
    assign out_data  = stage_in[SCALE_MULS];

endmodule

`default_nettype wire

[sv/sphav_norm.sv]
// division by mean density, one bit per stage, with saturation and result select
// depends on sphav_pkg
`default_nettype none

module sphav_norm import sphav_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  quot_t in_data,
    output logic  out_valid,
    output out_t  out_data
);

    localparam int SHIFT = NORM_STEPS - FRAC_BITS;

    typedef struct packed {
        logic [RHO_W-1:0]      rem;
        logic [NORM_STEPS-1:0] qx;
        logic [RHO_W-1:0]      robar;
        logic                  neg;
        logic                  zero_div;
        logic                  ovf;
    } nstage_t;

    logic [NORM_STEPS:0] vld_reg;
    nstage_t             st_reg [0:NORM_STEPS];
    nstage_t             last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NORM_STEPS-1:0], in_valid};
        end
    end

    // result of 2^31 or more shows as q >> 15 already >= mean density
    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0].rem      <= in_data.q[SHIFT +: RHO_W];
            st_reg[0].qx       <= {in_data.q[SHIFT-1:0], {FRAC_BITS{1'b0}}};
            st_reg[0].robar    <= in_data.robar;
            st_reg[0].neg      <= in_data.neg;
            st_reg[0].zero_div <= in_data.zero_div;
            st_reg[0].ovf      <= in_data.ovf || (in_data.q[Q_W-1:SHIFT] >= in_data.robar);
        end
    end

    for (genvar j = 0; j < NORM_STEPS; j++) begin : g_step
        logic [RHO_W:0] trial;
        logic [RHO_W:0] diff;
        logic           take;

        assign trial = {st_reg[j].rem, st_reg[j].qx[NORM_STEPS-1]};
        assign diff  = trial - {1'b0, st_reg[j].robar};
        assign take  = trial >= {1'b0, st_reg[j].robar};

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[j+1].rem      <= take ? diff[RHO_W-1:0] : trial[RHO_W-1:0];
                st_reg[j+1].qx       <= {st_reg[j].qx[NORM_STEPS-2:0], take};
                st_reg[j+1].robar    <= st_reg[j].robar;
                st_reg[j+1].neg      <= st_reg[j].neg;
                st_reg[j+1].zero_div <= st_reg[j].zero_div;
                st_reg[j+1].ovf      <= st_reg[j].ovf;
            end
        end
    end

    assign last = st_reg[NORM_STEPS];

    always_comb begin
        if (!last.neg) begin
            out_data.visc_term   = '0;
            out_data.approaching = 1'b0;
            out_data.saturated   = 1'b0;
        end else if (last.zero_div || last.ovf) begin
            out_data.visc_term   = VISC_MAX;
            out_data.approaching = 1'b1;
            out_data.saturated   = 1'b1;
        end else begin
            out_data.visc_term   = {1'b0, last.qx};
            out_data.approaching = 1'b1;
            out_data.saturated   = 1'b0;
        end
    end

    assign out_valid = vld_reg[NORM_STEPS];

endmodule

`default_nettype wire

[sv/sph_artificial_viscosity_unit.sv]
// top level of the sph artificial viscosity unit: config registers, pipeline, output skid
// depends on sphav_pkg, sphav_front, sphav_quot, sphav_scale, sphav_norm
//
// Takes one particle pair per cycle while s_ready is high and returns one viscosity result
// per pair, in order. The pair passes 105 register stages, the first loaded at the input
// transfer itself. The depth is set by the two dividers, each built as a chain of stages
// that settle one quotient bit apiece (63 stages for the scaled dot product over the
// divisor, 32 for the division by the mean density, each including an entry stage that
// checks for overflow), plus three front stages, six multiplier stages and the output
// register. The whole pipeline advances together; a stalled output fills a one-entry skid
// stage, after which s_ready drops until the skid drains. Configuration writes take effect
// at once and must only be made while no pair is in flight.
`default_nettype none

module sph_artificial_viscosity_unit import sphav_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_t                  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_t                 m_data,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [CFG_W-1:0]     cfg_wr_data
);

    cfg_t   cfg_reg;
    logic   en;
    logic   front_valid;
    front_t front_data;
    logic   quot_valid;
    quot_t  quot_data;
    logic   scale_valid;
    quot_t  scale_data;
    logic   norm_valid;
    out_t   norm_data;
    logic   mv_reg;
    out_t   m_reg;
    logic   sk_valid_reg;
    out_t   sk_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.smoothing_length <= SMOOTHING_LENGTH_RST;
            cfg_reg.alpha_coeff      <= ALPHA_COEFF_RST;
            cfg_reg.sound_speed      <= SOUND_SPEED_RST;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_SMOOTHING_LENGTH: begin
                    cfg_reg.smoothing_length <= cfg_wr_data;
                end
                REG_ALPHA_COEFF: begin
                    cfg_reg.alpha_coeff <= cfg_wr_data;
                end
                REG_SOUND_SPEED: begin
                    cfg_reg.sound_speed <= cfg_wr_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign en      = !sk_valid_reg;
    assign s_ready = en;

    sphav_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .cfg       (cfg_reg),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    sphav_quot u_quot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .out_valid (quot_valid),
        .out_data  (quot_data)
    );

    sphav_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (quot_valid),
        .in_data   (quot_data),
        .cfg       (cfg_reg),
        .out_valid (scale_valid),
        .out_data  (scale_data)
    );

    sphav_norm u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (scale_valid),
        .in_data   (scale_data),
        .out_valid (norm_valid),
        .out_data  (norm_data)
    );

    // output register plus one skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg       <= 1'b0;
            sk_valid_reg <= 1'b0;
        end else if (sk_valid_reg) begin
            if (m_ready) begin
                sk_valid_reg <= 1'b0;
            end
        end else if (norm_valid) begin
            if (mv_reg && !m_ready) begin
                sk_valid_reg <= 1'b1;
            end else begin
                mv_reg <= 1'b1;
            end
        end else if (m_ready) begin
            mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (sk_valid_reg) begin
            if (m_ready) begin
                m_reg <= sk_reg;
            end
        end else if (norm_valid) begin
            if (mv_reg && !m_ready) begin
                sk_reg <= norm_data;
            end else begin
                m_reg <= norm_data;
            end
        end
    end

    assign m_valid = mv_reg;
    assign m_data  = m_reg;

    a_skid_behind_output: assert property (@(posedge aclk) disable iff (!aresetn)
        sk_valid_reg |-> mv_reg)
        else $error("skid entry held without an output item");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        sk_valid_reg && m_ready |=> !sk_valid_reg)
        else $error("skid entry not released after output transfer");

    a_separating_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        mv_reg && !m_reg.approaching |-> m_reg.visc_term == '0 && !m_reg.saturated)
        else $error("separating pair gave non-zero result");

    a_saturated_max: assert property (@(posedge aclk) disable iff (!aresetn)
        mv_reg && m_reg.saturated |-> m_reg.visc_term == VISC_MAX && m_reg.approaching)
        else $error("saturated result not at maximum");

endmodule

`default_nettype wire

[tb/tb_top.sv]
// self-checking testbench for sph_artificial_viscosity_unit: directed table, then random pairs
// depends on sphav_pkg and unit rtl; predicts results in fixed point unless a row gives one
`default_nettype none

module tb_top;
    import sphav_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 120;
    localparam int PHASE_ITEMS    = 140;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_t                  s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_t                 m_data;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index = REG_SMOOTHING_LENGTH;
    logic [CFG_W-1:0]     cfg_wr_data = '0;

    logic [CFG_W-1:0] h_len = SMOOTHING_LENGTH_RST;
    logic [CFG_W-1:0] alpha = ALPHA_COEFF_RST;
    logic [CFG_W-1:0] cbar  = SOUND_SPEED_RST;

    typedef struct {
        in_t  pair;
        bit   known;
        out_t want;
    } row_t;

    out_t visc_expected[$];
    row_t pair_table[$];
    bit   row_known = 1'b0;
    out_t row_want = '0;
    bit   quiet = 1'b0;
    int   pairs_sent = 0;
    int   results_seen = 0;
    int   approach_seen = 0;
    int   sat_seen = 0;
    int   errors = 0;
    int   idle_cycles = 0;
    int   stall_left = 0;

    sph_artificial_viscosity_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic out_t visc_predict(in_t d);
        logic signed [65:0] pa [3];
        logic signed [65:0] va [3];
        logic signed [65:0] acc;
        logic signed [65:0] dotv;
        logic [63:0]  hh, eta2, den, robar, m, q;
        logic [127:0] wide;
        logic [CFG_W-1:0] scale [3];
        logic ovf;
        out_t r;
        pa[0] = d.rel_pos_x; pa[1] = d.rel_pos_y; pa[2] = d.rel_pos_z;
        va[0] = d.rel_vel_x; va[1] = d.rel_vel_y; va[2] = d.rel_vel_z;
        acc = pa[0] * va[0] + pa[1] * va[1] + pa[2] * va[2];
        dotv = acc >>> 16;
        r = '0;
        if (dotv >= 0) return r;
        r.approaching = 1'b1;
        hh = 64'(h_len) * 64'(h_len);
        eta2 = (((hh >> 32) * 64'(ETA_FRAC))
               + (((hh & 64'hFFFF_FFFF) * 64'(ETA_FRAC)) >> 32)) >> 16;
        den = 64'(d.dist_squared) + eta2;
        robar = (64'(d.density_a) + 64'(d.density_b)) >> 1;
        m = 64'(-dotv);
        if (den == 0 || robar == 0) begin
            r.visc_term = VISC_MAX;
            r.saturated = 1'b1;
            return r;
        end
        q = (m << 16) / den;
        ovf = (q >= 64'd1 << 62);
        scale[0] = h_len; scale[1] = alpha; scale[2] = cbar;
        for (int i = 0; i < 3; i++) begin
            if (!ovf) begin
                wide = (128'(q) * 128'(scale[i])) >> 16;
                if (wide >= 128'd1 << 62) ovf = 1'b1;
                else q = wide[63:0];
            end
        end
        if (!ovf) begin
            wide = (128'(q) << 16) / 128'(robar);
            if (wide > 128'h7FFF_FFFF) ovf = 1'b1;
            else r.visc_term = wide[31:0];
        end
        if (ovf) begin
            r.visc_term = VISC_MAX;
            r.saturated = 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch on result %0d: %s got %0h want %0h", results_seen, field, got, want);
        errors++;
    endtask

    // transfers and checks on the rising edge; watchdog on idle cycles
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                visc_expected.push_back(row_known ? row_want : visc_predict(s_data));
                pairs_sent++;
            end
            if (m_valid && m_ready) begin
                if (visc_expected.size() == 0) begin
                    $display("unexpected result: visc %0h", m_data.visc_term);
                    errors++;
                end else begin
                    out_t w;
                    w = visc_expected.pop_front();
                    if (m_data.visc_term !== w.visc_term)
                        report_mismatch("visc_term", m_data.visc_term, w.visc_term);
                    if (m_data.approaching !== w.approaching)
                        report_mismatch("approaching", m_data.approaching, w.approaching);
                    if (m_data.saturated !== w.saturated)
                        report_mismatch("saturated", m_data.saturated, w.saturated);
                end
                results_seen++;
                approach_seen += m_data.approaching;
                sat_seen += m_data.saturated;
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d results outstanding", visc_expected.size());
                $display("sph_artificial_viscosity_unit regression: fail");
                $finish;
            end
        end
    end

    // receiver stalls in bursts
    always @(negedge aclk) begin
        if (quiet || !aresetn) begin
            m_ready = 1'b1;
        end else if (stall_left > 0) begin
            m_ready = 1'b0;
            stall_left--;
        end else begin
            if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 5);
            m_ready = (stall_left == 0);
            if (stall_left > 0) stall_left--;
        end
    end

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2, 3: return $signed($urandom);
            default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        endcase
    endfunction

    function automatic logic [30:0] rand_mag(int zero_odds);
        case ($urandom_range(0, 9))
            0: return (zero_odds > 0 && $urandom_range(0, zero_odds) == 0) ? '0 : 31'h7FFF_FFFF;
            1: return 31'($urandom);
            2: return (zero_odds > 0) ? '0 : 31'd1;
            default: return 31'($urandom_range(1, 32'h0010_0000));
        endcase
    endfunction

    // mostly approaching pairs with random content, some separating noise
    function automatic in_t rand_pair();
        in_t d;
        d.rel_pos_x = rand_coord();
        d.rel_pos_y = rand_coord();
        d.rel_pos_z = rand_coord();
        d.rel_vel_x = rand_coord();
        d.rel_vel_y = rand_coord();
        d.rel_vel_z = rand_coord();
        if ($urandom_range(0, 3) != 0) begin
            if ((d.rel_pos_x < 0) == (d.rel_vel_x < 0)) d.rel_vel_x = ~d.rel_vel_x;
            if ((d.rel_pos_y < 0) == (d.rel_vel_y < 0)) d.rel_vel_y = ~d.rel_vel_y;
            if ((d.rel_pos_z < 0) == (d.rel_vel_z < 0)) d.rel_vel_z = ~d.rel_vel_z;
        end
        d.dist_squared = rand_mag(3);
        d.density_a = rand_mag(6);
        d.density_b = rand_mag(6);
        return d;
    endfunction

    function automatic in_t mk_pair(int px, int py, int pz, int vx, int vy, int vz,
                                    int rr, int ra, int rb);
        in_t d;
        d.rel_pos_x = px; d.rel_pos_y = py; d.rel_pos_z = pz;
        d.rel_vel_x = vx; d.rel_vel_y = vy; d.rel_vel_z = vz;
        d.dist_squared = 31'(rr); d.density_a = 31'(ra); d.density_b = 31'(rb);
        return d;
    endfunction

    task automatic add_row(in_t d, bit known = 1'b0, out_t want = '0);
        row_t r;
        r.pair = d; r.known = known; r.want = want;
        pair_table.push_back(r);
    endtask

    task automatic send_pair(in_t d, bit known, out_t want);
        int sent;
        sent = pairs_sent;
        s_valid = 1'b1;
        s_data = d;
        row_known = known;
        row_want = want;
        while (pairs_sent == sent) @(negedge aclk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_wr_en = 1'b1;
        cfg_wr_index = idx;
        cfg_wr_data = value;
        case (idx)
            REG_SMOOTHING_LENGTH: h_len = value;
            REG_ALPHA_COEFF:      alpha = value;
            default:              cbar = value;
        endcase
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (visc_expected.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) send_pair(rand_pair(), 1'b0, '0);
        drain();
    endtask

    initial begin
        out_t zero_res, sat_res;
        zero_res = '0;
        sat_res = '{visc_term: VISC_MAX, approaching: 1'b1, saturated: 1'b1};

        add_row(mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, zero_res);
        add_row(mk_pair(65536, 0, 0, 65536, 0, 0, 65536, 65536, 65536), 1'b1, zero_res);
        add_row(mk_pair(65536, 0, 0, -65536, 0, 0, 65536, 0, 0), 1'b1, sat_res);
        add_row(mk_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1, 1), 1'b1, sat_res);
        add_row(mk_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 1, 1), 1'b1, sat_res);
        add_row(mk_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 1, 1), 1'b1, zero_res);
        add_row(mk_pair(65536, 0, 0, -65536, 0, 0, 65536, 65536, 65536));
        add_row(mk_pair(0, 65536, 0, 0, -32768, 0, 16384, 65536000, 65536000));
        add_row(mk_pair(0, 0, -131072, 0, 0, 65536, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF));
        add_row(mk_pair(-1, 0, 0, 1, 0, 0, 0, 1, 0));
        add_row(mk_pair(1, 1, 1, -1, -1, -1, 0, 65536, 65536));
        add_row(mk_pair(65536, 65536, 0, -65536, 65536, 0, 65536, 65536, 65536), 1'b1,
                zero_res);
        add_row(mk_pair(3 * 65536, -2 * 65536, 65536, -65536, 65536, -65536,
                        14 * 65536, 1000 * 65536, 998 * 65536));
        add_row(mk_pair(32'h4000_0000, 0, 0, -65536, 0, 0, 1, 32'h7FFF_FFFF, 0));

        repeat (11) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (pair_table[i]) send_pair(pair_table[i].pair, pair_table[i].known,
                                          pair_table[i].want);
        row_known = 1'b0;
        drain();
        random_phase(PHASE_ITEMS);

        // tiny smoothing length: zero divisor when the distance is zero
        write_reg(REG_SMOOTHING_LENGTH, 31'd1);
        write_reg(REG_ALPHA_COEFF, 31'h7FFF_FFFF);
        write_reg(REG_SOUND_SPEED, 31'h7FFF_FFFF);
        random_phase(PHASE_ITEMS);

        write_reg(REG_SMOOTHING_LENGTH, 31'h7FFF_FFFF);
        write_reg(REG_ALPHA_COEFF, 31'd0);
        write_reg(REG_SOUND_SPEED, 31'd1);
        random_phase(PHASE_ITEMS);

        write_reg(REG_SMOOTHING_LENGTH, 31'($urandom_range(1, 32'h0004_0000)));
        write_reg(REG_ALPHA_COEFF, 31'($urandom_range(0, 32'h0002_0000)));
        write_reg(REG_SOUND_SPEED, 31'($urandom_range(0, 32'h0100_0000)));
        random_phase(PHASE_ITEMS);

        // last stretch at full rate on both sides
        write_reg(REG_SMOOTHING_LENGTH, SMOOTHING_LENGTH_RST);
        write_reg(REG_ALPHA_COEFF, ALPHA_COEFF_RST);
        write_reg(REG_SOUND_SPEED, SOUND_SPEED_RST);
        quiet = 1'b1;
        random_phase(PHASE_ITEMS);

        $display("pairs in: %0d, results out: %0d (approaching %0d, saturated %0d)",
                 pairs_sent, results_seen, approach_seen, sat_seen);
        $display("five register settings incl. extremes, mismatches: %0d", errors);
        if (errors == 0 && visc_expected.size() == 0)
            $display("sph_artificial_viscosity_unit regression: pass");
        else
            $display("sph_artificial_viscosity_unit regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
sv/sphav_pkg.sv
sv/sphav_front.sv
sv/sphav_quot.sv
sv/sphav_scale.sv
sv/sphav_norm.sv
sv/sph_artificial_viscosity_unit.sv
tb/tb_top.sv
